// ===== hdl/append_transfer_ack_tracker_macros.svh =====
// Assertion macros used by the append transfer tracker top level.
`ifndef APPEND_TRANSFER_ACK_TRACKER_MACROS_SVH
`define APPEND_TRANSFER_ACK_TRACKER_MACROS_SVH

// Checked only while out of reset.
`define ATAT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ATAT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/atat_pkg.sv =====
// Package: widths, codes and interface types of the append transfer tracker.
package atat_pkg;

	localparam int OFF_BITS      = 48;
	localparam int LINE_BITS     = 32;
	localparam int SEQ_BITS      = 63;
	localparam int OP_BITS       = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_ADDR_BITS = 6;
	localparam int REG_IDX_BITS  = 3;
	localparam int REG_IDX_LSB   = 3;

	localparam logic [OP_BITS-1:0] OP_START       = 3'd0;
	localparam logic [OP_BITS-1:0] OP_CREATE_SENT = 3'd1;
	localparam logic [OP_BITS-1:0] OP_DATA_SENT   = 3'd2;
	localparam logic [OP_BITS-1:0] OP_CREATE_RSND = 3'd3;
	localparam logic [OP_BITS-1:0] OP_DATA_RSND   = 3'd4;
	localparam logic [OP_BITS-1:0] OP_HEARTBEAT   = 3'd5;
	localparam logic [OP_BITS-1:0] OP_LOST        = 3'd6;
	localparam logic [OP_BITS-1:0] OP_CLEAR       = 3'd7;

	localparam logic [REG_IDX_BITS-1:0] REG_TASK_SEQUENCE  = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_START_POSITION = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_LENGTH  = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_ENTRY_ABSENT   = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_NEEDS_SYNC     = 3'd4;

	typedef struct packed {
		logic [SEQ_BITS-1:0] task_sequence;
		logic [OFF_BITS-1:0] start_position;
		logic [OFF_BITS-1:0] source_length;
		logic                entry_absent;
		logic                needs_sync;
	} cfg_t;

	typedef struct packed {
		logic [OP_BITS-1:0]   operation;
		logic [LINE_BITS-1:0] line_number;
		logic [OFF_BITS-1:0]  chunk_length;
		logic [OFF_BITS-1:0]  range_begin;
		logic [OFF_BITS-1:0]  range_finish;
		logic [SEQ_BITS-1:0]  peer_next_seq;
		logic [OFF_BITS-1:0]  peer_offset;
		logic [OFF_BITS-1:0]  peer_durable;
		logic                 lost_is_data;
		logic [SEQ_BITS-1:0]  lost_sequence;
		logic [OFF_BITS-1:0]  lost_position;
	} item_t;

	typedef struct packed {
		logic                 create_acked;
		logic                 data_acked;
		logic                 transfer_done;
		logic                 lost_match;
		logic                 in_flight;
		logic                 create_is_ready;
		logic [OFF_BITS-1:0]  acked_position;
		logic [LINE_BITS-1:0] create_line;
		logic [LINE_BITS-1:0] data_line;
	} res_t;

endpackage

// ===== hdl/atat_cfg.sv =====
// Configuration register file with APB-style access.
module atat_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [atat_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [atat_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [atat_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output atat_pkg::cfg_t                      cfg
);

	atat_pkg::cfg_t                       cfg_q;
	logic [atat_pkg::REG_IDX_BITS-1:0]    idx;
	logic                                 wr_en;

	assign idx    = paddr[atat_pkg::REG_IDX_LSB +: atat_pkg::REG_IDX_BITS];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.task_sequence  <= '0;
			cfg_q.start_position <= '0;
			cfg_q.source_length  <= '0;
			cfg_q.entry_absent   <= 1'b0;
			cfg_q.needs_sync     <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				atat_pkg::REG_TASK_SEQUENCE:
					cfg_q.task_sequence <= pwdata[atat_pkg::SEQ_BITS-1:0];
				atat_pkg::REG_START_POSITION:
					cfg_q.start_position <= pwdata[atat_pkg::OFF_BITS-1:0];
				atat_pkg::REG_SOURCE_LENGTH:
					cfg_q.source_length <= pwdata[atat_pkg::OFF_BITS-1:0];
				atat_pkg::REG_ENTRY_ABSENT: cfg_q.entry_absent <= pwdata[0];
				atat_pkg::REG_NEEDS_SYNC:   cfg_q.needs_sync   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			atat_pkg::REG_TASK_SEQUENCE:
				prdata[atat_pkg::SEQ_BITS-1:0] = cfg_q.task_sequence;
			atat_pkg::REG_START_POSITION:
				prdata[atat_pkg::OFF_BITS-1:0] = cfg_q.start_position;
			atat_pkg::REG_SOURCE_LENGTH:
				prdata[atat_pkg::OFF_BITS-1:0] = cfg_q.source_length;
			atat_pkg::REG_ENTRY_ABSENT: prdata[0] = cfg_q.entry_absent;
			atat_pkg::REG_NEEDS_SYNC:   prdata[0] = cfg_q.needs_sync;
			default: prdata = '0;
		endcase
	end

endmodule

// ===== hdl/atat_core.sv =====
// Transfer state registers and the per-transaction update logic.
module atat_core (
	input  logic            clk,
	input  logic            arst_n,
	input  atat_pkg::cfg_t  cfg,
	input  atat_pkg::item_t item,
	input  logic            step,
	output atat_pkg::res_t  res
);

	logic                           cpend_q, cdone_q, dpend_q, needs_q;
	logic [atat_pkg::LINE_BITS-1:0] cline_q, dline_q;
	logic [atat_pkg::OFF_BITS-1:0]  clen_q, npos_q;
	logic [atat_pkg::SEQ_BITS-1:0]  seq_q;

	logic                           cpend_d, cdone_d, dpend_d, needs_d;
	logic [atat_pkg::LINE_BITS-1:0] cline_d, dline_d;
	logic [atat_pkg::OFF_BITS-1:0]  clen_d, npos_d;
	logic [atat_pkg::SEQ_BITS-1:0]  seq_d;

	logic                           old_seq, c_ack, d_ack, done, match;
	logic [atat_pkg::OFF_BITS-1:0]  target;

	// expected sequence is seq+1 without wrap, i.e. peer_next_seq > seq
	assign old_seq = item.peer_next_seq <= seq_q;
	assign target  = npos_q + clen_q;

	always_comb begin
		cpend_d = cpend_q;
		cdone_d = cdone_q;
		dpend_d = dpend_q;
		needs_d = needs_q;
		cline_d = cline_q;
		dline_d = dline_q;
		clen_d  = clen_q;
		npos_d  = npos_q;
		seq_d   = seq_q;
		c_ack   = 1'b0;
		d_ack   = 1'b0;
		done    = 1'b0;
		match   = 1'b0;
		case (item.operation)
			atat_pkg::OP_START: begin
				needs_d = cfg.entry_absent;
				npos_d  = cfg.start_position;
				seq_d   = cfg.task_sequence;
				cdone_d = !cfg.entry_absent;
				cpend_d = 1'b0;
				dpend_d = 1'b0;
				cline_d = '0;
				dline_d = '0;
				clen_d  = '0;
			end
			atat_pkg::OP_CREATE_SENT, atat_pkg::OP_CREATE_RSND: begin
				cpend_d = 1'b1;
				cline_d = item.line_number;
			end
			atat_pkg::OP_DATA_SENT: begin
				dpend_d = 1'b1;
				dline_d = item.line_number;
				clen_d  = item.chunk_length;
			end
			atat_pkg::OP_DATA_RSND: begin
				dpend_d = 1'b1;
				dline_d = item.line_number;
				if (item.range_finish > item.range_begin) begin
					clen_d = item.range_finish - item.range_begin;
				end
			end
			atat_pkg::OP_HEARTBEAT: begin
				if (needs_q && cpend_q && !cdone_q &&
				    !(old_seq && item.peer_offset != '0)) begin
					cdone_d = 1'b1;
					c_ack   = 1'b1;
				end
				if (dpend_q && !(old_seq && item.peer_offset < target &&
				                 item.peer_durable < target)) begin
					npos_d  = target;
					dpend_d = 1'b0;
					dline_d = '0;
					clen_d  = '0;
					d_ack   = 1'b1;
				end
				if (!dpend_d && npos_d >= cfg.source_length && !old_seq) begin
					done = !cfg.needs_sync || item.peer_durable >= cfg.source_length;
				end
			end
			atat_pkg::OP_LOST: begin
				if (!item.lost_is_data) begin
					match = cpend_q && item.lost_sequence == seq_q;
				end else begin
					match = dpend_q && item.lost_sequence == seq_q &&
					        item.lost_position == npos_q;
				end
			end
			atat_pkg::OP_CLEAR: begin
				cpend_d = 1'b0;
				cdone_d = 1'b0;
				dpend_d = 1'b0;
				cline_d = '0;
				dline_d = '0;
				clen_d  = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpend_q <= 1'b0;
			cdone_q <= 1'b0;
			dpend_q <= 1'b0;
			needs_q <= 1'b0;
			cline_q <= '0;
			dline_q <= '0;
			clen_q  <= '0;
			npos_q  <= '0;
			seq_q   <= '0;
		end else if (step) begin
			cpend_q <= cpend_d;
			cdone_q <= cdone_d;
			dpend_q <= dpend_d;
			needs_q <= needs_d;
			cline_q <= cline_d;
			dline_q <= dline_d;
			clen_q  <= clen_d;
			npos_q  <= npos_d;
			seq_q   <= seq_d;
		end
	end

	assign res.create_acked    = c_ack;
	assign res.data_acked      = d_ack;
	assign res.transfer_done   = done;
	assign res.lost_match      = match;
	assign res.in_flight       = cpend_d || dpend_d;
	assign res.create_is_ready = cdone_d;
	assign res.acked_position  = npos_d;
	assign res.create_line     = cline_d;
	assign res.data_line       = dline_d;

endmodule

// ===== hdl/append_transfer_ack_tracker.sv =====
// Top level: append transfer acknowledgment tracker with input and result registers.
//
// Usage:
//   Events enter on the input channel (in_valid/in_ready); each transaction
//   carries an operation code and its operand fields. Exactly one result
//   transaction leaves on the output channel (out_valid/out_ready) for
//   every event, in order.
//   out_valid rises once an accepted event has passed from the input
//   register into the result register. Throughput is one event per cycle
//   while out_ready stays high: the input register and the result register
//   form a two-stage pipeline, and the tracker state is updated as an event
//   moves from the input register into the result register.
//   When the receiver stalls, one finished result waits in the result
//   register and one more event is held in the input register; in_ready
//   drops only when both are occupied and out_ready is low.
//   Registers are written over the APB-style port (8-byte spacing, pready
//   always high); the user must write them only while no event is in
//   flight (not enforced by the block). Reset clears the tracker state and
//   both pipeline valids; the durability register resets to 1, all others to 0.
`include "append_transfer_ack_tracker_macros.svh"

module append_transfer_ack_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [atat_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [atat_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [atat_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [atat_pkg::OP_BITS-1:0]       operation,
	input  logic [atat_pkg::LINE_BITS-1:0]     line_number,
	input  logic [atat_pkg::OFF_BITS-1:0]      chunk_length,
	input  logic [atat_pkg::OFF_BITS-1:0]      range_begin,
	input  logic [atat_pkg::OFF_BITS-1:0]      range_finish,
	input  logic [atat_pkg::SEQ_BITS-1:0]      peer_next_seq,
	input  logic [atat_pkg::OFF_BITS-1:0]      peer_offset,
	input  logic [atat_pkg::OFF_BITS-1:0]      peer_durable,
	input  logic                               lost_is_data,
	input  logic [atat_pkg::SEQ_BITS-1:0]      lost_sequence,
	input  logic [atat_pkg::OFF_BITS-1:0]      lost_position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               create_acked,
	output logic                               data_acked,
	output logic                               transfer_done,
	output logic                               lost_match,
	output logic                               in_flight,
	output logic                               create_is_ready,
	output logic [atat_pkg::OFF_BITS-1:0]      acked_position,
	output logic [atat_pkg::LINE_BITS-1:0]     create_line,
	output logic [atat_pkg::LINE_BITS-1:0]     data_line
);

	atat_pkg::cfg_t  cfg;
	atat_pkg::item_t item_in, item_s1;
	atat_pkg::res_t  res, res_s2;
	logic            valid_s1, valid_s2, advance, in_take;

	atat_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item_in.operation     = operation;
	assign item_in.line_number   = line_number;
	assign item_in.chunk_length  = chunk_length;
	assign item_in.range_begin   = range_begin;
	assign item_in.range_finish  = range_finish;
	assign item_in.peer_next_seq = peer_next_seq;
	assign item_in.peer_offset   = peer_offset;
	assign item_in.peer_durable  = peer_durable;
	assign item_in.lost_is_data  = lost_is_data;
	assign item_in.lost_sequence = lost_sequence;
	assign item_in.lost_position = lost_position;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || !valid_s2 || out_ready;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	atat_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.step   (advance),
		.res    (res)
	);

	assign out_valid       = valid_s2;
	assign create_acked    = res_s2.create_acked;
	assign data_acked      = res_s2.data_acked;
	assign transfer_done   = res_s2.transfer_done;
	assign lost_match      = res_s2.lost_match;
	assign in_flight       = res_s2.in_flight;
	assign create_is_ready = res_s2.create_is_ready;
	assign acked_position  = res_s2.acked_position;
	assign create_line     = res_s2.create_line;
	assign data_line       = res_s2.data_line;

	`ATAT_ASSERT(a_stall_only_when_full, !in_ready |-> valid_s1 && valid_s2 && !out_ready, "in_ready low without a full pipeline")
	`ATAT_ASSERT(a_create_ack_ready, valid_s2 && res_s2.create_acked |-> res_s2.create_is_ready, "create acknowledged but not ready")
	`ATAT_ASSERT(a_data_ack_clears_line, valid_s2 && res_s2.data_acked |-> res_s2.data_line == '0, "data acknowledged with a live data line")
	`ATAT_ASSERT(a_stalled_result_holds, valid_s2 && !out_ready |=> valid_s2 && $stable(res_s2), "stalled result changed")
	`ATAT_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !valid_s1 && !valid_s2, "pipeline valid during reset")

endmodule

// ===== sim/tb_top.sv =====
// Testbench for append_transfer_ack_tracker: random and directed events, checked against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [atat_pkg::SEQ_BITS-1:0] SEQ_TOP = 63'h7FFF_FFFF_FFFF_FFFE;

	class tracker_scoreboard;
		bit [atat_pkg::SEQ_BITS-1:0]  cfg_sequence;
		bit [atat_pkg::OFF_BITS-1:0]  cfg_start;
		bit [atat_pkg::OFF_BITS-1:0]  cfg_source_len;
		bit                           cfg_entry_absent;
		bit                           cfg_regular = 1'b1;

		bit                           create_pending;
		bit                           create_done;
		bit                           data_pending;
		bit                           must_create;
		bit [atat_pkg::LINE_BITS-1:0] cline_exp;
		bit [atat_pkg::LINE_BITS-1:0] dline_exp;
		bit [atat_pkg::OFF_BITS-1:0]  chunk_len;
		bit [atat_pkg::OFF_BITS-1:0]  next_position;
		bit [atat_pkg::SEQ_BITS-1:0]  seq_latched;

		atat_pkg::res_t expected_status[$];
		int             mismatches;
		int             results_checked;

		function void set_reg(logic [atat_pkg::REG_IDX_BITS-1:0] idx,
				logic [atat_pkg::CFG_DATA_BITS-1:0] value);
			case (idx)
			atat_pkg::REG_TASK_SEQUENCE:  cfg_sequence = value[atat_pkg::SEQ_BITS-1:0];
			atat_pkg::REG_START_POSITION: cfg_start = value[atat_pkg::OFF_BITS-1:0];
			atat_pkg::REG_SOURCE_LENGTH:  cfg_source_len = value[atat_pkg::OFF_BITS-1:0];
			atat_pkg::REG_ENTRY_ABSENT:   cfg_entry_absent = value[0];
			atat_pkg::REG_NEEDS_SYNC:     cfg_regular = value[0];
			default: ;
			endcase
		endfunction

		function void clear_flight();
			create_pending = 1'b0;
			data_pending = 1'b0;
			cline_exp = '0;
			dline_exp = '0;
			chunk_len = '0;
		endfunction

		function void note_event(atat_pkg::item_t ev);
			atat_pkg::res_t              want;
			bit                          old_seq;
			bit [atat_pkg::OFF_BITS-1:0] target;
			want = '0;
			case (ev.operation)
			atat_pkg::OP_START: begin
				must_create = cfg_entry_absent;
				next_position = cfg_start;
				seq_latched = cfg_sequence;
				create_done = !cfg_entry_absent;
				clear_flight();
			end
			atat_pkg::OP_CREATE_SENT, atat_pkg::OP_CREATE_RSND: begin
				create_pending = 1'b1;
				cline_exp = ev.line_number;
			end
			atat_pkg::OP_DATA_SENT: begin
				data_pending = 1'b1;
				dline_exp = ev.line_number;
				chunk_len = ev.chunk_length;
			end
			atat_pkg::OP_DATA_RSND: begin
				data_pending = 1'b1;
				dline_exp = ev.line_number;
				if (ev.range_finish > ev.range_begin)
					chunk_len = ev.range_finish - ev.range_begin;
			end
			atat_pkg::OP_HEARTBEAT: begin
				old_seq = ev.peer_next_seq <= seq_latched;
				if (must_create && create_pending && !create_done &&
						!(old_seq && ev.peer_offset != '0)) begin
					create_done = 1'b1;
					want.create_acked = 1'b1;
				end
				if (data_pending) begin
					target = next_position + chunk_len;
					if (!(old_seq && ev.peer_offset < target && ev.peer_durable < target)) begin
						next_position = target;
						data_pending = 1'b0;
						dline_exp = '0;
						chunk_len = '0;
						want.data_acked = 1'b1;
					end
				end
				// sequence + 1 taken without wrap
				if (!data_pending && next_position >= cfg_source_len &&
						{1'b0, ev.peer_next_seq} >= {1'b0, seq_latched} + 64'd1)
					want.transfer_done = !cfg_regular || ev.peer_durable >= cfg_source_len;
			end
			atat_pkg::OP_LOST: begin
				if (ev.lost_is_data)
					want.lost_match = data_pending && ev.lost_sequence == seq_latched &&
						ev.lost_position == next_position;
				else
					want.lost_match = create_pending && ev.lost_sequence == seq_latched;
			end
			atat_pkg::OP_CLEAR: begin
				clear_flight();
				create_done = 1'b0;
			end
			default: ;
			endcase
			want.in_flight = create_pending || data_pending;
			want.create_is_ready = create_done;
			want.acked_position = next_position;
			want.create_line = cline_exp;
			want.data_line = dline_exp;
			expected_status.push_back(want);
		endfunction

		task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch in result %0d, %s: got %h expected %h",
					results_checked, what, got, want);
		endtask

		task check_status(atat_pkg::res_t got);
			atat_pkg::res_t want;
			if (expected_status.size() == 0) begin
				flag_mismatch("unexpected result", got.acked_position, '0);
				return;
			end
			want = expected_status.pop_front();
			if (got.create_acked !== want.create_acked)
				flag_mismatch("create_acked", got.create_acked, want.create_acked);
			if (got.data_acked !== want.data_acked)
				flag_mismatch("data_acked", got.data_acked, want.data_acked);
			if (got.transfer_done !== want.transfer_done)
				flag_mismatch("transfer_done", got.transfer_done, want.transfer_done);
			if (got.lost_match !== want.lost_match)
				flag_mismatch("lost_match", got.lost_match, want.lost_match);
			if (got.in_flight !== want.in_flight)
				flag_mismatch("in_flight", got.in_flight, want.in_flight);
			if (got.create_is_ready !== want.create_is_ready)
				flag_mismatch("create_is_ready", got.create_is_ready, want.create_is_ready);
			if (got.acked_position !== want.acked_position)
				flag_mismatch("acked_position", got.acked_position, want.acked_position);
			if (got.create_line !== want.create_line)
				flag_mismatch("create_line", got.create_line, want.create_line);
			if (got.data_line !== want.data_line)
				flag_mismatch("data_line", got.data_line, want.data_line);
			results_checked++;
		endtask
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               psel;
	logic                               penable;
	logic                               pwrite;
	logic [atat_pkg::CFG_ADDR_BITS-1:0] paddr;
	logic [atat_pkg::CFG_DATA_BITS-1:0] pwdata;
	logic [atat_pkg::CFG_DATA_BITS-1:0] prdata;
	logic                               pready;
	logic                               in_valid;
	logic                               in_ready;
	atat_pkg::item_t                    in_item;
	logic                               out_valid;
	logic                               out_ready;
	logic                               create_acked;
	logic                               data_acked;
	logic                               transfer_done;
	logic                               lost_match;
	logic                               in_flight;
	logic                               create_is_ready;
	logic [atat_pkg::OFF_BITS-1:0]      acked_position;
	logic [atat_pkg::LINE_BITS-1:0]     create_line;
	logic [atat_pkg::LINE_BITS-1:0]     data_line;

	tracker_scoreboard sb;
	int                hold_cycles;
	bit                tx_jitter;
	bit                rx_jitter;
	int                items_sent;
	int unsigned       cycle_count;

	append_transfer_ack_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(in_item.operation),
		.line_number(in_item.line_number),
		.chunk_length(in_item.chunk_length),
		.range_begin(in_item.range_begin),
		.range_finish(in_item.range_finish),
		.peer_next_seq(in_item.peer_next_seq),
		.peer_offset(in_item.peer_offset),
		.peer_durable(in_item.peer_durable),
		.lost_is_data(in_item.lost_is_data),
		.lost_sequence(in_item.lost_sequence),
		.lost_position(in_item.lost_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.create_acked(create_acked),
		.data_acked(data_acked),
		.transfer_done(transfer_done),
		.lost_match(lost_match),
		.in_flight(in_flight),
		.create_is_ready(create_is_ready),
		.acked_position(acked_position),
		.create_line(create_line),
		.data_line(data_line)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : result_sink
		int gap;
		gap = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_status({create_acked, data_acked, transfer_done, lost_match, in_flight,
					create_is_ready, acked_position, create_line, data_line});
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				out_ready <= 1'b0;
			end else if (rx_jitter && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(0, 11);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [atat_pkg::OFF_BITS-1:0] random_offset();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[atat_pkg::OFF_BITS-1:0];
	endfunction

	function automatic logic [atat_pkg::SEQ_BITS-1:0] random_seq();
		logic [63:0] r;
		r = {$urandom, $urandom} >> 1;
		if (r[atat_pkg::SEQ_BITS-1:0] == '1)
			r = r - 1;
		return r[atat_pkg::SEQ_BITS-1:0];
	endfunction

	function automatic logic [atat_pkg::OFF_BITS-1:0] near_offset(
			logic [atat_pkg::OFF_BITS-1:0] base);
		case ($urandom_range(0, 6))
		0: return base + 1'b1;
		1: return base - 1'b1;
		2: return '0;
		3: return '1;
		4: return random_offset();
		default: return base;
		endcase
	endfunction

	function automatic logic [atat_pkg::SEQ_BITS-1:0] near_seq(
			logic [atat_pkg::SEQ_BITS-1:0] base);
		case ($urandom_range(0, 6))
		0: return base + 1'b1;
		1: return base - 1'b1;
		2: return '0;
		3: return '1;
		4: return random_seq();
		default: return base;
		endcase
	endfunction

	function automatic atat_pkg::item_t noise_event();
		logic [511:0] raw;
		for (int k = 0; k < 16; k++)
			raw[k*32 +: 32] = $urandom;
		return atat_pkg::item_t'(raw[$bits(atat_pkg::item_t)-1:0]);
	endfunction

	// Random payload, with the fields that matter for op pulled toward the tracker's state.
	function automatic atat_pkg::item_t shaped_event(logic [atat_pkg::OP_BITS-1:0] op);
		atat_pkg::item_t               ev;
		logic [atat_pkg::OFF_BITS-1:0] target;
		ev = noise_event();
		ev.operation = op;
		target = sb.next_position + sb.chunk_len;
		case (op)
		atat_pkg::OP_DATA_SENT: begin
			case ($urandom_range(0, 9))
			0: ev.chunk_length = '0;
			1: ev.chunk_length = '1;
			2, 3: ev.chunk_length = sb.cfg_source_len - sb.next_position;
			4: ;
			default: ev.chunk_length = $urandom_range(1, 512);
			endcase
		end
		atat_pkg::OP_DATA_RSND: begin
			if ($urandom_range(0, 1))
				ev.range_begin = sb.next_position;
			case ($urandom_range(0, 3))
			0: ev.range_finish = ev.range_begin;
			1: ev.range_finish = ev.range_begin - $urandom_range(1, 64);
			default: ev.range_finish = ev.range_begin + $urandom_range(1, 600);
			endcase
		end
		atat_pkg::OP_HEARTBEAT: begin
			if ($urandom_range(0, 1)) begin
				ev.peer_next_seq = sb.seq_latched + 1'b1;
				case ($urandom_range(0, 3))
				0: ev.peer_durable = sb.cfg_source_len;
				1: ev.peer_durable = '1;
				2: ev.peer_durable = target;
				default: ;
				endcase
			end else begin
				ev.peer_next_seq = near_seq(sb.seq_latched);
				ev.peer_offset = near_offset(target);
				ev.peer_durable = near_offset($urandom_range(0, 1) ? target : sb.cfg_source_len);
			end
		end
		atat_pkg::OP_LOST: begin
			ev.lost_sequence = $urandom_range(0, 3) ? sb.seq_latched : near_seq(sb.seq_latched);
			ev.lost_position = $urandom_range(0, 3) ? sb.next_position :
				near_offset(sb.next_position);
		end
		default: ;
		endcase
		return ev;
	endfunction

	task automatic pause_sender(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_event(atat_pkg::item_t ev);
		if (tx_jitter && $urandom_range(0, 5) == 0)
			pause_sender($urandom_range(1, 12));
		in_item <= ev;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_event(ev);
		items_sent++;
	endtask

	task automatic send_fields(input logic [atat_pkg::OP_BITS-1:0] op,
			input logic [atat_pkg::LINE_BITS-1:0] line,
			input logic [atat_pkg::OFF_BITS-1:0] len, beg, fin,
			input logic [atat_pkg::SEQ_BITS-1:0] hseq,
			input logic [atat_pkg::OFF_BITS-1:0] hoff, hdur, input logic lkind,
			input logic [atat_pkg::SEQ_BITS-1:0] lseq,
			input logic [atat_pkg::OFF_BITS-1:0] lpos);
		atat_pkg::item_t ev;
		ev.operation = op;
		ev.line_number = line;
		ev.chunk_length = len;
		ev.range_begin = beg;
		ev.range_finish = fin;
		ev.peer_next_seq = hseq;
		ev.peer_offset = hoff;
		ev.peer_durable = hdur;
		ev.lost_is_data = lkind;
		ev.lost_sequence = lseq;
		ev.lost_position = lpos;
		send_event(ev);
	endtask

	task automatic wait_for_results();
		while (sb.expected_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [atat_pkg::REG_IDX_BITS-1:0] idx,
			logic [atat_pkg::CFG_DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, {atat_pkg::REG_IDX_LSB{1'b0}}};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Only called with the sender stopped and every result back.
	task automatic apply_settings(logic [atat_pkg::SEQ_BITS-1:0] seq_v,
			logic [atat_pkg::OFF_BITS-1:0] start_v,
			logic [atat_pkg::OFF_BITS-1:0] src_v, logic cm, logic rf);
		write_reg(atat_pkg::REG_TASK_SEQUENCE, seq_v);
		write_reg(atat_pkg::REG_START_POSITION, start_v);
		write_reg(atat_pkg::REG_SOURCE_LENGTH, src_v);
		write_reg(atat_pkg::REG_ENTRY_ABSENT, cm);
		write_reg(atat_pkg::REG_NEEDS_SYNC, rf);
	endtask

	task automatic run_transfer();
		int chunks;
		send_event(shaped_event(atat_pkg::OP_START));
		if (sb.must_create && $urandom_range(0, 4) != 0) begin
			send_event(shaped_event(atat_pkg::OP_CREATE_SENT));
			if ($urandom_range(0, 2) == 0)
				send_event(shaped_event(atat_pkg::OP_LOST));
			if ($urandom_range(0, 3) == 0)
				send_event(shaped_event(atat_pkg::OP_CREATE_RSND));
			send_event(shaped_event(atat_pkg::OP_HEARTBEAT));
		end
		chunks = $urandom_range(1, 5);
		repeat (chunks) begin
			send_event(shaped_event(atat_pkg::OP_DATA_SENT));
			if ($urandom_range(0, 3) == 0)
				send_event(shaped_event(atat_pkg::OP_LOST));
			if ($urandom_range(0, 4) == 0)
				send_event(shaped_event(atat_pkg::OP_DATA_RSND));
			repeat ($urandom_range(1, 2))
				send_event(shaped_event(atat_pkg::OP_HEARTBEAT));
		end
		if ($urandom_range(0, 7) == 0)
			send_event(shaped_event(atat_pkg::OP_CLEAR));
	endtask

	initial begin : stimulus
		logic [atat_pkg::SEQ_BITS-1:0] s_seq;
		logic [atat_pkg::OFF_BITS-1:0] s_start;
		logic [atat_pkg::OFF_BITS-1:0] s_src;
		logic                          s_cm;
		logic                          s_rf;
		int                            goal;
		bit                            drained_mid;
		sb = new;
		hold_cycles = 0;
		items_sent = 0;
		drained_mid = 1'b0;
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		in_item <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before any start, reset settings
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_DATA_SENT, '1, '1, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, 63'd1, '0, '1, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_LOST, '0, '0, '0, '0, '0, '0, '0, 1'b1, '0, '1);
		send_fields(atat_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		pause_sender(1);
		wait_for_results();
		apply_settings(63'd5, 48'd1000, 48'd1300, 1'b1, 1'b1);
		send_fields(atat_pkg::OP_START, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_LOST, '0, '0, '0, '0, '0, '0, '0, 1'b0, 63'd5, '0);
		send_fields(atat_pkg::OP_CREATE_SENT, '1, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_LOST, '0, '0, '0, '0, '0, '0, '0, 1'b0, 63'd5, '0);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, 63'd5, 48'd7, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, 63'd5, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_DATA_SENT, 32'd1, 48'd100, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_DATA_RSND, 32'd2, '0, 48'd10, 48'd10, '0, '0, '0, 1'b0,
			'0, '0);
		send_fields(atat_pkg::OP_DATA_RSND, 32'd3, '0, 48'd50, 48'd20, '0, '0, '0, 1'b0,
			'0, '0);
		send_fields(atat_pkg::OP_DATA_RSND, 32'd4, '0, 48'd20, 48'd220, '0, '0, '0, 1'b0,
			'0, '0);
		send_fields(atat_pkg::OP_LOST, '0, '0, '0, '0, '0, '0, '0, 1'b1, 63'd5, 48'd1000);
		send_fields(atat_pkg::OP_LOST, '0, '0, '0, '0, '0, '0, '0, 1'b1, 63'd5, 48'd999);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, 63'd5, 48'd1199, 48'd1199, 1'b0,
			'0, '0);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, 63'd5, '0, 48'd1200, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_DATA_SENT, 32'd5, 48'd100, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, 63'd6, '0, 48'd1299, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, 63'd6, '0, 48'd1300, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_CREATE_RSND, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, '1, '0, '1, 1'b0, '0, '0);
		pause_sender(1);
		wait_for_results();
		// offset wraps past the top of the range
		apply_settings(SEQ_TOP, 48'hFFFF_FFFF_FFF0, '0, 1'b0, 1'b0);
		send_fields(atat_pkg::OP_START, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_DATA_SENT, 32'd9, 48'd32, '0, '0, '0, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, '1, '0, '0, 1'b0, '0, '0);
		send_fields(atat_pkg::OP_HEARTBEAT, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0);

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
			0: begin
				s_seq = '0;
				s_start = '0;
				s_src = $urandom_range(0, 3000);
				s_cm = 1'b1;
				s_rf = 1'b1;
			end
			1: begin
				s_seq = SEQ_TOP;
				s_start = '1;
				s_src = '1;
				s_cm = 1'b0;
				s_rf = 1'b0;
			end
			2: begin
				s_seq = $urandom_range(1, 1000);
				s_start = random_offset();
				s_src = s_start + $urandom_range(0, 4000);
				s_cm = 1'b1;
				s_rf = 1'b0;
			end
			3: begin
				s_seq = random_seq();
				s_start = '1 - $urandom_range(0, 2000);
				s_src = s_start + $urandom_range(0, 1500);
				s_cm = 1'($urandom_range(0, 1));
				s_rf = 1'b1;
			end
			default: begin
				s_seq = random_seq();
				s_start = $urandom_range(0, 1) ? random_offset() : $urandom_range(0, 5000);
				s_src = $urandom_range(0, 3) ? s_start + $urandom_range(0, 4000) :
					random_offset();
				s_cm = 1'($urandom_range(0, 1));
				s_rf = 1'($urandom_range(0, 1));
			end
			endcase
			pause_sender(1);
			wait_for_results();
			apply_settings(s_seq, s_start, s_src, s_cm, s_rf);
			goal = items_sent + 200;
			// receiver holds off while the sender keeps offering
			if (phase == 1)
				hold_cycles = 150;
			while (items_sent < goal) begin
				tx_jitter = phase != 7 && $urandom_range(0, 3) != 0;
				rx_jitter = phase != 7 && $urandom_range(0, 3) != 0;
				if (phase == 2 && !drained_mid && items_sent > goal - 100) begin
					pause_sender(1);
					wait_for_results();
					drained_mid = 1'b1;
				end
				if ($urandom_range(0, 6) == 0)
					repeat ($urandom_range(1, 4)) send_event(noise_event());
				else
					run_transfer();
			end
		end

		pause_sender(1);
		wait_for_results();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_status.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== append_transfer_ack_tracker.f =====
+incdir+hdl
hdl/atat_pkg.sv
hdl/atat_cfg.sv
hdl/atat_core.sv
hdl/append_transfer_ack_tracker.sv
sim/tb_top.sv
